// File: rtl/core/lart_pkg.sv
package lart_pkg;

	localparam int SLOTS_DEF       = 8;
	localparam int FRAME_BYTES_DEF = 255;
	localparam int STRIDE_W        = 8;
	localparam int FADDR_W         = 13;
	localparam int IN_TDATA_W      = 152;
	localparam int OUT_TDATA_W     = 136;

	localparam logic [2:0] MODE_TRACK = 3'd0;
	localparam logic [2:0] MODE_LOAD  = 3'd1;
	localparam logic [2:0] MODE_ACK   = 3'd2;
	localparam logic [2:0] MODE_TICK  = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;
	localparam logic [2:0] MODE_SEQ   = 3'd5;

	localparam logic [2:0] KIND_TRACK  = 3'd0;
	localparam logic [2:0] KIND_LOAD   = 3'd1;
	localparam logic [2:0] KIND_ACK    = 3'd2;
	localparam logic [2:0] KIND_RESEND = 3'd3;
	localparam logic [2:0] KIND_SUMRD  = 3'd4;
	localparam logic [2:0] KIND_SEQ    = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TOO_LONG = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NO_ACK   = 3'd3;
	localparam logic [2:0] ST_BAD_ADDR = 3'd4;

	typedef struct packed {
		logic [7:0]  seq;
		logic [31:0] hop;
		logic [7:0]  retries;
		logic [31:0] interval;
		logic [31:0] due;
		logic [7:0]  length;
	} slot_entry_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [FADDR_W-1:0] addr;
		logic [7:0]         wdata;
	} fr_req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  status;
		logic [2:0]  slot;
		logic [7:0]  seq;
		logic [31:0] hop;
		logic [7:0]  len;
		logic [7:0]  data;
		logic [3:0]  drop;
		logic        last;
	} result_t;

endpackage

// File: rtl/core/link_arq_retransmit_tracker_unit.sv
// track, load and next sequence run execute then emit; read adds a frame RAM wait before emit
// ack reads and checks the slot table one entry at a time until a match or the last slot
// tick makes two passes over the slot table before the summary, and output stalls can hold it:
// one pass finds drops, one resends
// throughput: one transaction at a time, the next is taken once the last result is registered
// reset: arst_n clears slot valid bits, counters and handshake state; memories are not cleared
module link_arq_retransmit_tracker_unit #(
	parameter int SLOTS       = lart_pkg::SLOTS_DEF,
	parameter int FRAME_BYTES = lart_pkg::FRAME_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// sequence, hop, frame length, time, interval, retry budget, frame byte,
	// slot index, byte offset, zero fill
	input  logic [lart_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// mode
	input  logic [2:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status, slot, sequence, hop, length, data byte, drops this tick,
	// slots in use, ack total, drop total, zero fill
	output logic [lart_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// kind
	output logic [2:0]                          m_axis_tuser,
	output logic                                m_axis_tlast
);
	import lart_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_A_RD, S_A_CHK, S_T1_RD, S_T1_CHK,
		S_T2_RD, S_T2_CHK, S_T_SUM, S_R_WAIT, S_EMIT
	} state_t;

	state_t state_q, ret_q;

	logic [2:0]  mode_q;
	logic [7:0]  seq_in_q, retr_q, fbyte_q, off_q;
	logic [31:0] hop_q, now_q, tmo_q;
	logic [15:0] flen_q;
	logic [2:0]  sidx_q;

	logic [SLOTS-1:0] used_q, drop_mask_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       seq_ctr_q;
	logic [31:0]      acked_q, dropped_q;
	logic [3:0]       drop_now_q;
	result_t          res_q;
	result_t          exec_res;

	logic                     out_valid_q;
	logic [OUT_TDATA_W-1:0]   out_data_q;
	logic [2:0]               out_kind_q;
	logic                     out_last_q;

	slot_entry_t tbl [SLOTS];
	slot_entry_t tbl_rd_q;
	logic        tbl_we;
	logic [IDX_W-1:0] tbl_waddr;
	slot_entry_t tbl_wdata;

	fr_req_t    fr_req;
	logic [7:0] fr_rdata;

	// lowest free slot
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	logic        too_long, addr_ok, last_idx, cur_used, cur_due;
	logic [7:0]  seq_next;
	logic [31:0] due_diff;
	logic [IDX_W-1:0] sidx_w;
	logic        out_free;
	logic [SLOTS-1:0] mask_upd;

	assign too_long = 32'(flen_q) > FRAME_BYTES;
	assign addr_ok  = (32'(sidx_q) < SLOTS) && (32'(off_q) < FRAME_BYTES);
	assign last_idx = idx_q == IDX_W'(SLOTS - 1);
	assign cur_used = used_q[idx_q];
	assign due_diff = now_q - tbl_rd_q.due;
	assign cur_due  = cur_used && !due_diff[31];
	assign seq_next = (seq_ctr_q == 8'hff) ? 8'd1 : seq_ctr_q + 8'd1;
	assign sidx_w   = IDX_W'(sidx_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign mask_upd = drop_mask_q |
		((cur_due && tbl_rd_q.retries == 8'd0) ? (SLOTS'(1) << idx_q) : '0);

	// track, load and next sequence settle their result in the execute cycle
	always_comb begin
		exec_res      = '0;
		exec_res.last = 1'b1;
		unique case (mode_q)
			MODE_TRACK: begin
				exec_res.kind = KIND_TRACK;
				if (too_long) begin
					exec_res.status = ST_TOO_LONG;
				end else if (!free_found) begin
					exec_res.status = ST_FULL;
				end else begin
					exec_res.slot = 3'(free_idx);
				end
			end
			MODE_LOAD: begin
				exec_res.kind   = KIND_LOAD;
				exec_res.status = addr_ok ? ST_OK : ST_BAD_ADDR;
			end
			MODE_SEQ: begin
				exec_res.kind = KIND_SEQ;
				exec_res.seq  = seq_next;
			end
			default: ;
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_q;
		tbl_wdata = tbl_rd_q;
		fr_req    = '0;
		fr_req.addr  = FADDR_W'({sidx_w, off_q});
		fr_req.wdata = fbyte_q;
		if (state_q == S_EXEC) begin
			unique case (mode_q)
				MODE_TRACK: begin
					tbl_we    = !too_long && free_found;
					tbl_waddr = free_idx;
					tbl_wdata = '{seq: seq_in_q, hop: hop_q, retries: retr_q,
						interval: tmo_q, due: now_q + tmo_q, length: flen_q[7:0]};
				end
				MODE_LOAD: fr_req.we = addr_ok;
				MODE_READ: fr_req.re = addr_ok;
				default: ;
			endcase
		end else if (state_q == S_T2_CHK && cur_due) begin
			tbl_we            = 1'b1;
			tbl_wdata.retries = tbl_rd_q.retries - 8'd1;
			tbl_wdata.due     = now_q + tbl_rd_q.interval;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl[tbl_waddr] <= tbl_wdata;
		end
		tbl_rd_q <= tbl[idx_q];
	end

	lart_frame_ram #(
		.DEPTH(SLOTS * 256)
	) u_frame_ram (
		.clk  (clk),
		.req  (fr_req),
		.rdata(fr_rdata)
	);

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q   <= s_axis_tuser;
			seq_in_q <= s_axis_tdata[7:0];
			hop_q    <= s_axis_tdata[39:8];
			flen_q   <= s_axis_tdata[55:40];
			now_q    <= s_axis_tdata[87:56];
			tmo_q    <= s_axis_tdata[119:88];
			retr_q   <= s_axis_tdata[127:120];
			fbyte_q  <= s_axis_tdata[135:128];
			sidx_q   <= s_axis_tdata[138:136];
			off_q    <= s_axis_tdata[146:139];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			used_q      <= '0;
			drop_mask_q <= '0;
			idx_q       <= '0;
			seq_ctr_q   <= '0;
			acked_q     <= '0;
			dropped_q   <= '0;
			drop_now_q  <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_kind_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (m_axis_tready && !(state_q == S_EMIT && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q   <= exec_res;
					ret_q   <= S_IDLE;
					idx_q   <= '0;
					state_q <= S_EMIT;
					unique case (mode_q)
						MODE_TRACK: begin
							if (!too_long && free_found) begin
								used_q[free_idx] <= 1'b1;
							end
						end
						MODE_LOAD: ;
						MODE_ACK: state_q <= S_A_RD;
						MODE_TICK: begin
							drop_mask_q <= '0;
							state_q     <= S_T1_RD;
						end
						MODE_READ: state_q <= S_R_WAIT;
						MODE_SEQ: seq_ctr_q <= seq_next;
						default: state_q <= S_IDLE;
					endcase
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					res_q.kind <= KIND_ACK;
					if (cur_used && tbl_rd_q.seq == seq_in_q) begin
						used_q[idx_q] <= 1'b0;
						acked_q       <= acked_q + 32'd1;
						state_q       <= S_EMIT;
					end else if (last_idx) begin
						res_q.status <= ST_NO_ACK;
						state_q      <= S_EMIT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_T1_RD: state_q <= S_T1_CHK;
				S_T1_CHK: begin
					drop_mask_q <= mask_upd;
					if (last_idx) begin
						// drops retire at once so later results see the final counts
						used_q     <= used_q & ~mask_upd;
						dropped_q  <= dropped_q + 32'($countones(mask_upd));
						drop_now_q <= 4'($countones(mask_upd));
						idx_q      <= '0;
						state_q    <= S_T2_RD;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_T1_RD;
					end
				end
				S_T2_RD: state_q <= S_T2_CHK;
				S_T2_CHK: begin
					idx_q <= idx_q + IDX_W'(1);
					if (cur_due) begin
						res_q   <= '{kind: KIND_RESEND, status: ST_OK, slot: 3'(idx_q),
							seq: tbl_rd_q.seq, hop: tbl_rd_q.hop, len: tbl_rd_q.length,
							data: 8'd0, drop: 4'd0, last: 1'b0};
						ret_q   <= last_idx ? S_T_SUM : S_T2_RD;
						state_q <= S_EMIT;
					end else begin
						state_q <= last_idx ? S_T_SUM : S_T2_RD;
					end
				end
				S_T_SUM: begin
					res_q   <= '{kind: KIND_SUMRD, status: ST_OK, slot: 3'd0, seq: 8'd0,
						hop: 32'd0, len: 8'd0, data: 8'd0, drop: drop_now_q, last: 1'b1};
					ret_q   <= S_IDLE;
					state_q <= S_EMIT;
				end
				S_R_WAIT: begin
					res_q.kind   <= KIND_SUMRD;
					res_q.status <= addr_ok ? ST_OK : ST_BAD_ADDR;
					res_q.slot   <= sidx_q;
					res_q.data   <= addr_ok ? fr_rdata : 8'd0;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= res_q.kind;
						out_last_q  <= res_q.last;
						out_data_q  <= {2'b0, dropped_q, acked_q, 4'($countones(used_q)),
							res_q.drop, res_q.data, res_q.len, res_q.hop, res_q.seq,
							res_q.slot, res_q.status};
						state_q     <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_ack_step: assert property (@(posedge clk) disable iff (!arst_n)
		acked_q != $past(acked_q) |-> acked_q == $past(acked_q) + 32'd1)
		else $error("ack counter jumped");

	a_no_drop_in_resend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_T2_CHK |-> (drop_mask_q & used_q) == '0)
		else $error("dropped slot still in use during resend pass");

	a_drop_pass_only: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q != $past(dropped_q) |-> $past(state_q) == S_T1_CHK)
		else $error("drop count changed outside the drop pass");

endmodule

// File: rtl/core/lart_frame_ram.sv
module lart_frame_ram #(
	parameter int DEPTH = lart_pkg::SLOTS_DEF * 256
) (
	input  logic             clk,
	input  lart_pkg::fr_req_t req,
	output logic [7:0]       rdata
);
	import lart_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr[AW-1:0]];
		end
	end

endmodule
